[rtl/acbc_pkg.sv]
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types and constants for the ARGB color key, brightness and contrast
// pipeline.
// ----------------------------------------------------------------------------
package acbc_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = CHAN_W + GAIN_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'hff;
  localparam logic [CHAN_W-1:0] CONTRAST_MID  = 8'd128;
  localparam logic [CHAN_W:0]   KEY_TOLERANCE = 9'd2;
  localparam logic [GAIN_W-1:0] UNITY_Q8      = 16'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RED           = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_GREEN         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BLUE          = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_ENABLE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_GAIN   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_ENABLE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_GAIN     = 4'd7;

  // Stage load enables and adjustment settings shared by the channel lanes.
  typedef struct packed {
    logic              load2;
    logic              load3;
    logic              load4;
    logic              bright_en;
    logic [GAIN_W-1:0] bright_gain;
    logic              contrast_en;
    logic [GAIN_W-1:0] contrast_gain;
  } chan_ctl_t;

endpackage

[rtl/argb_colorkey_brightness_contrast.sv]
// ----------------------------------------------------------------------------
// argb_colorkey_brightness_contrast
// Streaming ARGB32 pixel processor: color key, brightness and contrast.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel and leave on the m_ channel, one request per
// pixel, alpha in bits 31:24 down to blue in bits 7:0. The cfg channel writes
// one register per request (index 0..7; other indexes are ignored) and is
// always ready; write it only while no pixels are in flight.
// The datapath is a four-stage pipeline: color key compare, brightness
// multiply (8 x 16 bits per channel), saturation, and contrast add with
// clamping into the output register. A pixel passes through the key, product,
// saturation and output registers in turn before m_tvalid rises. A new pixel
// is accepted in every cycle while the output does not stall, so throughput
// is one pixel per clock.
// Each stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up. When the receiver stalls, the
// pipeline fills and s_tready drops only once all four stages hold pixels;
// nothing is dropped or repeated.
// Reset empties the pipeline and returns all configuration registers to their
// defaults: every stage disabled and both gains at unity.
// ----------------------------------------------------------------------------
module argb_colorkey_brightness_contrast (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [acbc_pkg::PIXEL_W-1:0]    s_tdata,   // pixel_in[31:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [acbc_pkg::PIXEL_W-1:0]    m_tdata,   // pixel_out[31:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [acbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = acbc_pkg::CHAN_W;

  logic                        key_enable;
  logic [CW-1:0]               key_red;
  logic [CW-1:0]               key_green;
  logic [CW-1:0]               key_blue;
  logic                        brightness_enable;
  logic [acbc_pkg::GAIN_W-1:0] brightness_gain;
  logic                        contrast_enable;
  logic [acbc_pkg::GAIN_W-1:0] contrast_gain;

  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;

  logic [CW-1:0] alpha1, alpha2, alpha3, alpha4;
  logic [CW-1:0] red1, green1, blue1;
  logic [CW-1:0] red4, green4, blue4;
  logic [CW-1:0] alpha1_next, red1_next, green1_next, blue1_next;

  logic [CW:0] diff_red, diff_green, diff_blue;
  logic        key_match;

  acbc_pkg::chan_ctl_t ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable        <= 1'b0;
      key_red           <= '0;
      key_green         <= '0;
      key_blue          <= '0;
      brightness_enable <= 1'b0;
      brightness_gain   <= acbc_pkg::UNITY_Q8;
      contrast_enable   <= 1'b0;
      contrast_gain     <= acbc_pkg::UNITY_Q8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acbc_pkg::CFG_KEY_ENABLE:        key_enable        <= cfg_data[0];
        acbc_pkg::CFG_KEY_RED:           key_red           <= cfg_data[CW-1:0];
        acbc_pkg::CFG_KEY_GREEN:         key_green         <= cfg_data[CW-1:0];
        acbc_pkg::CFG_KEY_BLUE:          key_blue          <= cfg_data[CW-1:0];
        acbc_pkg::CFG_BRIGHTNESS_ENABLE: brightness_enable <= cfg_data[0];
        acbc_pkg::CFG_BRIGHTNESS_GAIN:
          brightness_gain <= cfg_data[acbc_pkg::GAIN_W-1:0];
        acbc_pkg::CFG_CONTRAST_ENABLE:   contrast_enable   <= cfg_data[0];
        acbc_pkg::CFG_CONTRAST_GAIN:
          contrast_gain <= cfg_data[acbc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or its successor is taking its pixel.
  assign ready4   = !v4 || m_tready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_tvalid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  // Color key stage.
  always_comb begin
    diff_red   = (s_tdata[23:16] > key_red) ? {1'b0, s_tdata[23:16]} - {1'b0, key_red}
                                            : {1'b0, key_red} - {1'b0, s_tdata[23:16]};
    diff_green = (s_tdata[15:8] > key_green) ? {1'b0, s_tdata[15:8]} - {1'b0, key_green}
                                             : {1'b0, key_green} - {1'b0, s_tdata[15:8]};
    diff_blue  = (s_tdata[7:0] > key_blue) ? {1'b0, s_tdata[7:0]} - {1'b0, key_blue}
                                           : {1'b0, key_blue} - {1'b0, s_tdata[7:0]};
    key_match  = (diff_red <= acbc_pkg::KEY_TOLERANCE) &&
                 (diff_green <= acbc_pkg::KEY_TOLERANCE) &&
                 (diff_blue <= acbc_pkg::KEY_TOLERANCE);
    alpha1_next = s_tdata[31:24];
    red1_next   = s_tdata[23:16];
    green1_next = s_tdata[15:8];
    blue1_next  = s_tdata[7:0];
    if (key_enable) begin
      if (key_match) begin
        alpha1_next = '0;
        red1_next   = '0;
        green1_next = '0;
        blue1_next  = '0;
      end else begin
        alpha1_next = acbc_pkg::CHAN_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      alpha1 <= alpha1_next;
      red1   <= red1_next;
      green1 <= green1_next;
      blue1  <= blue1_next;
    end
    if (ready2) alpha2 <= alpha1;
    if (ready3) alpha3 <= alpha2;
    if (ready4) alpha4 <= alpha3;
  end

  assign ctl.load2         = ready2;
  assign ctl.load3         = ready3;
  assign ctl.load4         = ready4;
  assign ctl.bright_en     = brightness_enable;
  assign ctl.bright_gain   = brightness_gain;
  assign ctl.contrast_en   = contrast_enable;
  assign ctl.contrast_gain = contrast_gain;

  acbc_chan_adjust u_red (
    .clk      (clk),
    .ctl      (ctl),
    .chan_in  (red1),
    .chan_out (red4)
  );

  acbc_chan_adjust u_green (
    .clk      (clk),
    .ctl      (ctl),
    .chan_in  (green1),
    .chan_out (green4)
  );

  acbc_chan_adjust u_blue (
    .clk      (clk),
    .ctl      (ctl),
    .chan_in  (blue1),
    .chan_out (blue4)
  );

  assign m_tvalid = v4;
  assign m_tdata  = {alpha4, red4, green4, blue4};

  // Input backpressure only appears once every stage holds a pixel.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4))
    else $error("s_tready low while the pipeline has an empty stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted pixel did not reach the first stage");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v3 && ready4) |=> v4)
    else $error("pixel lost between stage three and the output register");

  a_key_alpha: assert property (@(posedge clk) disable iff (rst)
    (v1 && key_enable) |-> (alpha1 == '0 || alpha1 == acbc_pkg::CHAN_MAX))
    else $error("keyed stage produced an alpha other than 0 or 255");

endmodule

[rtl/acbc_chan_adjust.sv]
// ----------------------------------------------------------------------------
// acbc_chan_adjust
// One color channel lane: brightness multiply, saturation and contrast, over
// three register stages that follow the color key stage.
// ----------------------------------------------------------------------------
module acbc_chan_adjust (
  input  logic                        clk,
  input  acbc_pkg::chan_ctl_t         ctl,
  input  logic [acbc_pkg::CHAN_W-1:0] chan_in,
  output logic [acbc_pkg::CHAN_W-1:0] chan_out
);

  logic [acbc_pkg::PROD_W-1:0] prod;
  logic [acbc_pkg::PROD_W-1:0] prod_next;
  logic [acbc_pkg::CHAN_W-1:0] scaled;
  logic [acbc_pkg::CHAN_W-1:0] scaled_next;
  logic [acbc_pkg::CHAN_W-1:0] chan_out_next;

  logic signed [acbc_pkg::GAIN_W:0]   delta;
  logic signed [acbc_pkg::GAIN_W+2:0] sum;

  // With brightness off the channel is moved into Q8.8 position so the
  // saturation stage gives it back unchanged.
  always_comb begin
    if (ctl.bright_en) begin
      prod_next = acbc_pkg::PROD_W'(chan_in) * acbc_pkg::PROD_W'(ctl.bright_gain);
    end else begin
      prod_next = {{(acbc_pkg::GAIN_W - acbc_pkg::CHAN_W){1'b0}}, chan_in,
                   {acbc_pkg::CHAN_W{1'b0}}};
    end
  end

  always_comb begin
    if (prod[acbc_pkg::PROD_W-1:2*acbc_pkg::CHAN_W] != '0) begin
      scaled_next = acbc_pkg::CHAN_MAX;
    end else begin
      scaled_next = prod[2*acbc_pkg::CHAN_W-1:acbc_pkg::CHAN_W];
    end
  end

  always_comb begin
    delta = $signed({1'b0, ctl.contrast_gain}) - $signed({1'b0, acbc_pkg::UNITY_Q8});
    if (scaled > acbc_pkg::CONTRAST_MID) begin
      sum = $signed({{(acbc_pkg::GAIN_W - acbc_pkg::CHAN_W + 3){1'b0}}, scaled})
            + (acbc_pkg::GAIN_W+3)'(delta);
    end else begin
      sum = $signed({{(acbc_pkg::GAIN_W - acbc_pkg::CHAN_W + 3){1'b0}}, scaled})
            - (acbc_pkg::GAIN_W+3)'(delta);
    end
    if (!ctl.contrast_en) begin
      chan_out_next = scaled;
    end else if (sum < 0) begin
      chan_out_next = '0;
    end else if (sum > $signed({{(acbc_pkg::GAIN_W - acbc_pkg::CHAN_W + 3){1'b0}},
                                acbc_pkg::CHAN_MAX})) begin
      chan_out_next = acbc_pkg::CHAN_MAX;
    end else begin
      chan_out_next = sum[acbc_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      prod <= prod_next;
    end
    if (ctl.load3) begin
      scaled <= scaled_next;
    end
    if (ctl.load4) begin
      chan_out <= chan_out_next;
    end
  end

endmodule

[sim/tb_argb_colorkey_brightness_contrast.sv]
// ----------------------------------------------------------------------------
// tb_argb_colorkey_brightness_contrast
// Self-checking testbench for the ARGB color key, brightness and contrast
// pipeline. Directed tests cover the key tolerance window, gain extremes, the
// contrast midpoint and register masking. Randomized phases then stream
// pixels under changing settings with random stalls on both sides, and every
// output pixel is compared with a shadow copy of the datapath.
// ----------------------------------------------------------------------------
module tb_argb_colorkey_brightness_contrast;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_PIXELS   = 100;
  localparam int STALL_PIXELS   = 40;
  localparam int MAX_REPORTS    = 20;

  localparam logic [acbc_pkg::CFG_IDX_W-1:0] UNUSED_INDEX_FIRST = 4'd8;
  localparam logic [acbc_pkg::CFG_IDX_W-1:0] UNUSED_INDEX_LAST  = 4'd15;

  typedef struct packed {
    logic                        key_en;
    logic [7:0]                  key_r;
    logic [7:0]                  key_g;
    logic [7:0]                  key_b;
    logic                        bright_en;
    logic [acbc_pkg::GAIN_W-1:0] bright_gain;
    logic                        contrast_en;
    logic [acbc_pkg::GAIN_W-1:0] contrast_gain;
  } settings_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [acbc_pkg::PIXEL_W-1:0]    s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [acbc_pkg::PIXEL_W-1:0]    m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [acbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [acbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  settings_t                    shadow;
  logic [acbc_pkg::PIXEL_W-1:0] pending_pixels[$];
  int                           pixels_sent = 0;
  int                           pixels_checked = 0;
  int                           mismatch_count = 0;
  int                           reg_writes = 0;
  int                           settings_applied = 0;
  bit                           idle_on = 1'b1;
  bit                           long_hold_req = 1'b0;

  argb_colorkey_brightness_contrast u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // pixel_in[31:0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // pixel_out[31:0]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic settings_t make_settings(logic ke, logic [7:0] kr, logic [7:0] kg,
                                              logic [7:0] kb, logic be, logic [15:0] bg,
                                              logic ce, logic [15:0] cg);
    settings_t s;
    s.key_en        = ke;
    s.key_r         = kr;
    s.key_g         = kg;
    s.key_b         = kb;
    s.bright_en     = be;
    s.bright_gain   = bg;
    s.contrast_en   = ce;
    s.contrast_gain = cg;
    return s;
  endfunction

  function automatic bit near_key(logic [7:0] chan, logic [7:0] key);
    int diff;
    diff = int'(chan) - int'(key);
    if (diff < 0) diff = -diff;
    return diff <= int'(acbc_pkg::KEY_TOLERANCE);
  endfunction

  function automatic logic [7:0] brighten(logic [7:0] chan);
    logic [acbc_pkg::PROD_W-1:0] prod;
    prod = chan * shadow.bright_gain;
    if (prod[acbc_pkg::PROD_W-1:8] > acbc_pkg::CHAN_MAX) return acbc_pkg::CHAN_MAX;
    return prod[15:8];
  endfunction

  function automatic logic [7:0] stretch_contrast(logic [7:0] chan);
    int delta;
    int level;
    delta = int'(shadow.contrast_gain) - int'(acbc_pkg::UNITY_Q8);
    level = int'(chan);
    // The midpoint itself falls on the subtracting side.
    if (chan > acbc_pkg::CONTRAST_MID) level = level + delta;
    else level = level - delta;
    if (level < 0) level = 0;
    if (level > int'(acbc_pkg::CHAN_MAX)) level = int'(acbc_pkg::CHAN_MAX);
    return level[7:0];
  endfunction

  function automatic logic [acbc_pkg::PIXEL_W-1:0] predict_pixel(
      logic [acbc_pkg::PIXEL_W-1:0] px);
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    if (shadow.key_en) begin
      if (near_key(px[23:16], shadow.key_r) && near_key(px[15:8], shadow.key_g) &&
          near_key(px[7:0], shadow.key_b)) begin
        px = '0;
      end else begin
        px[31:24] = acbc_pkg::CHAN_MAX;
      end
    end
    red   = px[23:16];
    green = px[15:8];
    blue  = px[7:0];
    if (shadow.bright_en) begin
      red   = brighten(red);
      green = brighten(green);
      blue  = brighten(blue);
    end
    if (shadow.contrast_en) begin
      red   = stretch_contrast(red);
      green = stretch_contrast(green);
      blue  = stretch_contrast(blue);
    end
    return {px[31:24], red, green, blue};
  endfunction

  task automatic model_write(logic [acbc_pkg::CFG_IDX_W-1:0] idx,
                             logic [acbc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      acbc_pkg::CFG_KEY_ENABLE:        shadow.key_en        = data[0];
      acbc_pkg::CFG_KEY_RED:           shadow.key_r         = data[7:0];
      acbc_pkg::CFG_KEY_GREEN:         shadow.key_g         = data[7:0];
      acbc_pkg::CFG_KEY_BLUE:          shadow.key_b         = data[7:0];
      acbc_pkg::CFG_BRIGHTNESS_ENABLE: shadow.bright_en     = data[0];
      acbc_pkg::CFG_BRIGHTNESS_GAIN:   shadow.bright_gain   = data;
      acbc_pkg::CFG_CONTRAST_ENABLE:   shadow.contrast_en   = data[0];
      acbc_pkg::CFG_CONTRAST_GAIN:     shadow.contrast_gain = data;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- random values

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] random_gain();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return acbc_pkg::UNITY_Q8;
      3, 4, 5, 6: return 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_key();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Biased so that keyed pixels and the contrast midpoint show up often.
  function automatic logic [acbc_pkg::PIXEL_W-1:0] random_pixel();
    logic [acbc_pkg::PIXEL_W-1:0] px;
    logic [7:0]                   key;
    logic [7:0]                   jitter;
    int                           pick;
    pick = $urandom_range(9);
    px   = $urandom;
    for (int i = 0; i < 3; i++) begin
      key    = (i == 2) ? shadow.key_r : (i == 1) ? shadow.key_g : shadow.key_b;
      jitter = 8'($urandom_range(6));
      if (pick < 3) begin
        px[i*8 +: 8] = key + jitter - 8'd3;
      end else if (pick == 3) begin
        case ($urandom_range(4))
          0: px[i*8 +: 8] = 8'd0;
          1: px[i*8 +: 8] = acbc_pkg::CONTRAST_MID - 8'd1;
          2: px[i*8 +: 8] = acbc_pkg::CONTRAST_MID;
          3: px[i*8 +: 8] = acbc_pkg::CONTRAST_MID + 8'd1;
          default: px[i*8 +: 8] = acbc_pkg::CHAN_MAX;
        endcase
      end
    end
    return px;
  endfunction

  // ---------------------------------------------------------------- bus tasks

  task automatic send_pixel(logic [acbc_pkg::PIXEL_W-1:0] px);
    int gap;
    gap = (idle_on && $urandom_range(2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_pixels.push_back(predict_pixel(px));
    pixels_sent++;
  endtask

  // Settings may only change once the pipeline holds nothing.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [acbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [acbc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_write(idx, data);
    reg_writes++;
  endtask

  task automatic close_config();
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(settings_t s);
    drain_pipeline();
    write_reg(acbc_pkg::CFG_KEY_ENABLE, acbc_pkg::CFG_DATA_W'(s.key_en));
    write_reg(acbc_pkg::CFG_KEY_RED, acbc_pkg::CFG_DATA_W'(s.key_r));
    write_reg(acbc_pkg::CFG_KEY_GREEN, acbc_pkg::CFG_DATA_W'(s.key_g));
    write_reg(acbc_pkg::CFG_KEY_BLUE, acbc_pkg::CFG_DATA_W'(s.key_b));
    write_reg(acbc_pkg::CFG_BRIGHTNESS_ENABLE, acbc_pkg::CFG_DATA_W'(s.bright_en));
    write_reg(acbc_pkg::CFG_BRIGHTNESS_GAIN, s.bright_gain);
    write_reg(acbc_pkg::CFG_CONTRAST_ENABLE, acbc_pkg::CFG_DATA_W'(s.contrast_en));
    write_reg(acbc_pkg::CFG_CONTRAST_GAIN, s.contrast_gain);
    close_config();
    settings_applied++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_passthrough_defaults();
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h807f_8081);
  endtask

  task automatic test_color_key();
    apply_settings(make_settings(1'b1, 8'd100, 8'd150, 8'd200,
                                 1'b0, acbc_pkg::UNITY_Q8, 1'b0, acbc_pkg::UNITY_Q8));
    send_pixel({8'h12, 8'd100, 8'd150, 8'd200});
    send_pixel({8'h00, 8'd102, 8'd148, 8'd202});
    send_pixel({8'h34, 8'd103, 8'd150, 8'd200});
    send_pixel({8'h56, 8'd100, 8'd147, 8'd200});
    // Key at the channel extremes; the distance must not wrap around.
    apply_settings(make_settings(1'b1, 8'd0, 8'd255, 8'd0,
                                 1'b0, acbc_pkg::UNITY_Q8, 1'b0, acbc_pkg::UNITY_Q8));
    send_pixel({8'h77, 8'd2, 8'd253, 8'd0});
    send_pixel({8'h78, 8'd255, 8'd255, 8'd0});
  endtask

  task automatic test_brightness();
    apply_settings(make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                                 1'b1, 16'd384, 1'b0, acbc_pkg::UNITY_Q8));
    send_pixel(32'hff80_4001);
    apply_settings(make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                                 1'b1, 16'h0000, 1'b0, acbc_pkg::UNITY_Q8));
    send_pixel(32'hffff_ffff);
    apply_settings(make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                                 1'b1, 16'hffff, 1'b0, acbc_pkg::UNITY_Q8));
    send_pixel(32'h5a01_00ff);
  endtask

  task automatic test_contrast();
    apply_settings(make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                                 1'b0, acbc_pkg::UNITY_Q8, 1'b1, 16'd257));
    send_pixel(32'h1180_817f);
    send_pixel(32'h2200_ff80);
    apply_settings(make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                                 1'b0, acbc_pkg::UNITY_Q8, 1'b1, 16'h0000));
    send_pixel(32'h3380_8100);
    apply_settings(make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                                 1'b0, acbc_pkg::UNITY_Q8, 1'b1, 16'hffff));
    send_pixel(32'h4480_81ff);
  endtask

  // A keyed pixel still goes through both adjustment stages.
  task automatic test_key_then_adjust();
    apply_settings(make_settings(1'b1, 8'd50, 8'd60, 8'd70, 1'b1, 16'd512, 1'b1, 16'd200));
    send_pixel({8'hab, 8'd50, 8'd60, 8'd70});
    send_pixel({8'h01, 8'd10, 8'd100, 8'd200});
  endtask

  // Oversized values keep their low bits; unused indexes change nothing.
  task automatic test_register_writes();
    drain_pipeline();
    write_reg(acbc_pkg::CFG_KEY_ENABLE, 16'h8001);
    write_reg(acbc_pkg::CFG_KEY_RED, 16'hab10);
    write_reg(acbc_pkg::CFG_KEY_GREEN, 16'hcd20);
    write_reg(acbc_pkg::CFG_KEY_BLUE, 16'hef30);
    write_reg(4'($urandom_range(UNUSED_INDEX_FIRST, UNUSED_INDEX_LAST)), 16'($urandom));
    write_reg(UNUSED_INDEX_LAST, 16'hffff);
    write_reg(acbc_pkg::CFG_BRIGHTNESS_ENABLE, 16'hfffe);
    write_reg(acbc_pkg::CFG_CONTRAST_ENABLE, 16'h0002);
    close_config();
    send_pixel({8'h99, 8'h10, 8'h20, 8'h30});
    send_pixel({8'h99, 8'h10, 8'h20, 8'h33});
  endtask

  // The receiver holds off while requests keep coming, so the pipeline backs up.
  task automatic test_output_stall();
    apply_settings(make_settings(1'b1, random_key(), random_key(), random_key(), 1'b1,
                                 random_gain(), 1'b1, random_gain()));
    idle_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (STALL_PIXELS) send_pixel(random_pixel());
    idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_settings(make_settings(1'($urandom), random_key(), random_key(), random_key(),
                                   1'($urandom), random_gain(), 1'($urandom),
                                   random_gain()));
      idle_on = ($urandom_range(3) != 0);
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- processes

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(3) == 0) begin
        hold_left = gap_len() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : result_checker
    logic [acbc_pkg::PIXEL_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected pixel, expected none, actual %08h", $time, m_tdata);
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (m_tdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: pixel_out mismatch, expected %08h, actual %08h",
                       $time, want, m_tdata);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : test_sequence
    shadow = make_settings(1'b0, 8'd0, 8'd0, 8'd0,
                           1'b0, acbc_pkg::UNITY_Q8, 1'b0, acbc_pkg::UNITY_Q8);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_passthrough_defaults();
    test_color_key();
    test_brightness();
    test_contrast();
    test_key_then_adjust();
    test_register_writes();
    test_output_stall();
    test_random_settings();

    drain_pipeline();
    if (pending_pixels.size() != 0) mismatch_count++;

    $display("Streamed %0d pixels (%0d checked) across %0d register settings,",
             pixels_sent, pixels_checked, settings_applied);
    $display("using %0d register writes, a long output stall and random idling.",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/acbc_pkg.sv
rtl/acbc_chan_adjust.sv
rtl/argb_colorkey_brightness_contrast.sv
sim/tb_argb_colorkey_brightness_contrast.sv
